// ===== sv/ffha_pkg.sv =====
// ----------------------------------------------------------------------------
// ffha_pkg: shared types and constants for the first-fit heap allocator
// Field widths, default sizing, operation and status codes, and the chunk and
// probe records that move along the cell row.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned OFF_W    = 25;
  localparam int unsigned LEN_W    = 25;
  localparam int unsigned REQ_W    = 24;
  localparam int unsigned HBYTES_W = 25;

  localparam int unsigned MAX_CHUNKS_DEF = 64;
  localparam int unsigned HEADER_BYTES   = 32;
  localparam int unsigned MIN_ALLOC      = 64;
  localparam int unsigned HEAP_BYTES_RST = 65536;

  // register indexes on the config port
  localparam logic CFG_HEAP_BASE  = 1'b0;
  localparam logic CFG_HEAP_BYTES = 1'b1;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_INIT  = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_NULL    = 2'd3
  } status_e;

  // One chunk of the heap, as held by a cell.
  typedef struct packed {
    logic             vld;
    logic             used;
    logic [OFF_W-1:0] off;
    logic [LEN_W-1:0] len;
  } chunk_t;

  // Transaction walking down the row, one cell per cycle unless an output stall freezes the row.
  typedef struct packed {
    logic              vld;
    op_e               op;
    logic              skip;   // null free: search disabled
    logic              hit;
    logic [REQ_W-1:0]  need;
    logic [ADDR_W-1:0] tgt;    // free address minus heap base
    logic [OFF_W-1:0]  off;    // offset of the chunk that was hit
    chunk_t            cry;    // chunk being inserted / rippled along
  } probe_t;

endpackage

// ===== sv/first_fit_heap_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_unit: first-fit heap allocator with chunk split
// Address-ordered chunk table kept in a row of cells; allocate, free and
// reinitialize run as a probe that walks the row.
// ----------------------------------------------------------------------------
// The heap is kept as a row of MAX_CHUNKS cells holding the chunks in address
// order, the head chunk in cell 0. Each transaction becomes a probe that
// enters the row and moves one cell per cycle unless an output stall freezes
// the row; the first fitting free chunk (allocate) or the chunk whose address
// matches (free) is updated as the probe passes. A split hands the new free
// chunk to the probe, which then ripples the rest of the list one cell to the
// right on its way out; a reinitialize loads the fresh chunk into cell 0 and
// empties the rest. One transaction is in flight at a time: its probe passes
// from the entry register through each cell of the row, and its result is
// then loaded into the output register. The next input is accepted as soon as
// the probe has left the last cell, even while that result still waits to be
// taken. An output stall that holds a finished result back freezes a probe
// that reaches the end of the row. Configuration registers must only be
// written while no transaction is in flight.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_unit
  import ffha_pkg::*;
#(
  parameter int unsigned MAX_CHUNKS = MAX_CHUNKS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration writes
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [ADDR_W-1:0] cfg_wdata_i,
  // request transaction
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        op_i,
  input  logic [REQ_W-1:0]  req_size_i,
  input  logic [ADDR_W-1:0] addr_i,
  // result transaction
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ADDR_W-1:0] result_addr_o,
  output logic [1:0]        status_o
);

  // config registers
  logic [ADDR_W-1:0]   heap_base_q;
  logic [HBYTES_W-1:0] heap_bytes_q;

  // control
  logic   busy_q, busy_d;
  logic   accept;
  logic   adv;
  logic   last_vld;
  probe_t ent_q, ent_d;
  probe_t ext;

  // output register
  logic              out_vld_q, out_vld_d;
  logic [ADDR_W-1:0] res_q, res_d;
  status_e           sts_q, sts_d;

  logic [LEN_W-1:0]  init_len;
  logic [REQ_W-1:0]  need;

  probe_t                link [MAX_CHUNKS+1];
  logic [MAX_CHUNKS-1:0] cell_vld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_base_q  <= '0;
      heap_bytes_q <= HBYTES_W'(HEAP_BYTES_RST);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HEAP_BASE:  heap_base_q  <= cfg_wdata_i;
        CFG_HEAP_BYTES: heap_bytes_q <= cfg_wdata_i[HBYTES_W-1:0];
        default: ;
      endcase
    end
  end

  // A result at the end of the row may only leave into a free output slot.
  assign ext    = link[MAX_CHUNKS];
  assign adv    = !(ext.vld && out_vld_q && out_stall_i);
  assign accept = in_valid_i && !busy_q;

  // region smaller than a header leaves a zero-length chunk
  assign init_len = (heap_bytes_q > HBYTES_W'(HEADER_BYTES)) ?
                    LEN_W'(heap_bytes_q - HBYTES_W'(HEADER_BYTES)) : '0;
  assign need     = (req_size_i < REQ_W'(MIN_ALLOC)) ? REQ_W'(MIN_ALLOC) : req_size_i;

  // Build the probe for a new transaction.
  always_comb begin
    ent_d = ent_q;
    if (accept) begin
      ent_d      = '0;
      ent_d.vld  = 1'b1;
      ent_d.op   = op_e'(op_i);
      ent_d.need = need;
      ent_d.tgt  = addr_i - heap_base_q;
      ent_d.skip = (addr_i == '0);
      if (op_e'(op_i) == OP_INIT) begin
        ent_d.cry = '{vld: 1'b1, used: 1'b0, off: OFF_W'(HEADER_BYTES), len: init_len};
      end
    end else if (adv) begin
      ent_d.vld = 1'b0;
    end
  end

  always_comb begin
    busy_d = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (ext.vld && adv) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      ent_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      busy_q    <= busy_d;
      ent_q     <= ent_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Cell row; chunks fill the row from cell 0, so the table is full once
  // every cell holds one.
  assign link[0]  = ent_q;
  assign last_vld = &cell_vld;

  for (genvar k = 0; k < MAX_CHUNKS; k++) begin : g_cell
    ffha_cell #(
      .HEAD (k == 0)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .full_i (last_vld),
      .prb_i  (link[k]),
      .prb_o  (link[k+1]),
      .vld_o  (cell_vld[k])
    );
  end

  // Resolve the finished probe into a result.
  always_comb begin
    out_vld_d = out_vld_q;
    res_d     = res_q;
    sts_d     = sts_q;
    if (ext.vld && adv) begin
      out_vld_d = 1'b1;
      res_d     = '0;
      sts_d     = ST_OK;
      case (ext.op)
        OP_ALLOC: begin
          if (ext.hit) begin
            res_d = heap_base_q + ADDR_W'(ext.off);
          end else begin
            sts_d = ST_NOFIT;
          end
        end
        OP_FREE: begin
          if (ext.skip) begin
            sts_d = ST_NULL;
          end else if (ext.hit) begin
            res_d = heap_base_q + ADDR_W'(ext.off);
          end else begin
            sts_d = ST_UNKNOWN;
          end
        end
        default: ;
      endcase
    end else if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    sts_q <= sts_d;
  end

  assign in_stall_o    = busy_q;
  assign out_valid_o   = out_vld_q;
  assign result_addr_o = res_q;
  assign status_o      = sts_q;

endmodule

// ===== sv/ffha_cell.sv =====
// ----------------------------------------------------------------------------
// ffha_cell: one chunk slot of the address-ordered chunk row
// Holds a chunk, serves the probe passing through, and swaps in the carried
// chunk so a split ripples the tail of the list one slot to the right.
// ----------------------------------------------------------------------------
module ffha_cell
  import ffha_pkg::*;
#(
  parameter bit HEAD = 1'b0
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   adv_i,
  input  logic   full_i,
  input  probe_t prb_i,
  output probe_t prb_o,
  output logic   vld_o
);

  localparam chunk_t CellRst = '{
    vld:  HEAD,
    used: 1'b0,
    off:  HEAD ? OFF_W'(HEADER_BYTES) : '0,
    len:  HEAD ? LEN_W'(HEAP_BYTES_RST - HEADER_BYTES) : '0
  };
  localparam logic [LEN_W-1:0] SplitMin = LEN_W'(HEADER_BYTES + MIN_ALLOC);

  chunk_t           chk_q, chk_d;
  probe_t           prb_q, prb_d;
  logic [LEN_W-1:0] need_w;
  logic [LEN_W-1:0] extra;
  logic             fit;
  logic             split;
  logic             match;

  always_comb begin
    need_w = LEN_W'(prb_i.need);
    extra  = chk_q.len - need_w;
    fit    = chk_q.vld && !chk_q.used && (chk_q.len >= need_w);
    split  = (extra > SplitMin) && !full_i;
    match  = chk_q.vld && (prb_i.tgt[ADDR_W-1:OFF_W] == '0) &&
             (prb_i.tgt[OFF_W-1:0] == chk_q.off);
  end

  always_comb begin
    chk_d = chk_q;
    prb_d = prb_i;
    if (prb_i.vld) begin
      case (prb_i.op)
        OP_INIT: begin
          // head takes the fresh chunk, everything after it empties
          chk_d     = prb_i.cry;
          prb_d.cry = '0;
        end
        OP_ALLOC: begin
          if (prb_i.cry.vld) begin
            chk_d     = prb_i.cry;
            prb_d.cry = chk_q;
          end else if (!prb_i.hit && fit) begin
            prb_d.hit  = 1'b1;
            prb_d.off  = chk_q.off;
            chk_d.used = 1'b1;
            if (split) begin
              chk_d.len = need_w;
              prb_d.cry = '{
                vld:  1'b1,
                used: 1'b0,
                off:  chk_q.off + OFF_W'(prb_i.need) + OFF_W'(HEADER_BYTES),
                len:  extra - LEN_W'(HEADER_BYTES)
              };
            end
          end
        end
        OP_FREE: begin
          if (!prb_i.hit && !prb_i.skip && match) begin
            chk_d.used = 1'b0;
            prb_d.hit  = 1'b1;
            prb_d.off  = chk_q.off;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chk_q <= CellRst;
      prb_q <= '0;
    end else if (adv_i) begin
      chk_q <= chk_d;
      prb_q <= prb_d;
    end
  end

  assign prb_o = prb_q;
  assign vld_o = chk_q.vld;

endmodule
